// ===== rtl/bffa_pkg.sv =====
// Shared constants, types and codes for the first-fit bitmap block allocator.
// No dependencies; imported by bitmap_first_fit_allocator_core.
package bffa_pkg;

  localparam int unsigned NumBlocks  = 1024;
  localparam int unsigned BlockBytes = 4096;

  localparam int unsigned BlkAw   = $clog2(NumBlocks);       // block index bits
  localparam int unsigned BlkCw   = BlkAw + 1;               // counter that reaches NumBlocks
  localparam int unsigned BlkOfs  = $clog2(BlockBytes);      // byte offset bits in a block
  localparam int unsigned LenW    = 21;
  localparam int unsigned PosW    = 22;
  localparam int unsigned FreeW   = 23;
  localparam int unsigned StatW   = 2;
  localparam int unsigned BytesW  = LenW + 2;                // words to bytes
  localparam int unsigned CntW    = BytesW - BlkOfs + 1;     // rounded-up block count
  localparam int unsigned InDataW  = ((LenW + PosW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((StatW + PosW + FreeW + 7) / 8) * 8;

  localparam logic [FreeW-1:0] StoreBytes = FreeW'(NumBlocks * BlockBytes);
  localparam logic [BlkCw-1:0] BlkEnd     = BlkCw'(NumBlocks);
  localparam logic [BlkCw-1:0] BlkLast    = BlkCw'(NumBlocks - 1);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOMEM  = 2'd1,
    STAT_NORUN  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/bitmap_first_fit_allocator_core.sv =====
// First-fit bitmap block allocator: a 1024 x 1 block-use memory walked by one
// sequencer with a single compare/count unit. Depends on bffa_pkg.
//
// One request is in work at a time; s_axis_tready_o is high only when the
// sequencer is idle. After reset a clearing pass writes every bitmap entry,
// one per cycle, before the first request is taken. An allocate request
// scans the bitmap one block per cycle through the memory's single
// registered read port, then marks the run through the one write port. A
// request that fails the free-byte check or asks for zero words goes
// straight to its result. A free request clears its blocks one per cycle
// through the write port, stopping at the end of the store. The result sits
// in an output register, so the core returns to idle while an earlier
// result still waits to be taken, and waits only if a new result is ready
// before the old one is gone.
module bitmap_first_fit_allocator_core
  import bffa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [20:0] length_words, [42:21] free_position, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] cmd
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] status, [23:2] position_bytes, [46:24] free_bytes_left, rest zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  state_e               state_q, state_d;
  logic [BlkCw-1:0]     idx_q, idx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      run_q, run_d;
  logic [BlkAw-1:0]     start_q, start_d;
  logic [BytesW-1:0]    bytes_q, bytes_d;
  logic [FreeW-1:0]     free_q, free_d;
  status_e              stat_q, stat_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 rdv_q;
  logic [BlkAw-1:0]     eval_q;
  logic                 rd_data_q;
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;

  logic                 mem_q [NumBlocks];
  logic                 rd_en;
  logic                 wr_en;
  logic                 wr_bit;

  logic [LenW-1:0]      in_len;
  logic [PosW-1:0]      in_pos;
  logic [BytesW-1:0]    in_bytes;
  logic [BytesW:0]      in_round;
  logic [CntW-1:0]      in_cnt;
  logic [CntW-1:0]      run_inc;
  logic [BlkAw-1:0]     run_start;
  logic [FreeW:0]       credit_sum;
  logic                 s_acc;

  assign in_len   = s_axis_tdata_i[LenW-1:0];
  assign in_pos   = s_axis_tdata_i[LenW+PosW-1:LenW];
  assign in_bytes = {in_len, 2'b00};
  assign in_round = {1'b0, in_bytes} + (BytesW+1)'(BlockBytes - 1);
  assign in_cnt   = CntW'(in_round >> BlkOfs);
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;

  assign run_inc    = run_q + CntW'(1);
  assign run_start  = (run_q == '0) ? eval_q : start_q;
  assign credit_sum = {1'b0, free_q} + (FreeW+1)'(bytes_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    start_d   = start_q;
    bytes_d   = bytes_q;
    free_d    = free_q;
    stat_d    = stat_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_bit    = 1'b0;

    // drop the result once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_q + BlkCw'(1);
        if (idx_q == BlkLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          bytes_d = in_bytes;
          cnt_d   = in_cnt;
          pos_d   = '0;
          stat_d  = STAT_OK;
          if (cmd_e'(s_axis_tuser_i) == CMD_FREE) begin
            idx_d   = BlkCw'(in_pos >> BlkOfs);
            state_d = ST_FREE;
          end else if ((FreeW+1)'(in_bytes) > (FreeW+1)'(free_q)) begin
            stat_d  = STAT_NOMEM;
            state_d = ST_DONE;
          end else if (in_cnt == '0) begin
            stat_d  = STAT_NORUN;
            state_d = ST_DONE;
          end else begin
            idx_d   = '0;
            run_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, evaluate the bit read in the cycle before
        if (idx_q != BlkEnd) begin
          rd_en = 1'b1;
          idx_d = idx_q + BlkCw'(1);
        end
        if (rdv_q) begin
          if (!rd_data_q) begin
            run_d   = run_inc;
            start_d = run_start;
            if (run_inc == cnt_q) begin
              idx_d   = BlkCw'(run_start);
              pos_d   = PosW'(run_start) << BlkOfs;
              state_d = ST_MARK;
            end
          end else begin
            run_d = '0;
          end
        end else if (idx_q == BlkEnd) begin
          stat_d  = STAT_NORUN;
          state_d = ST_DONE;
        end
      end
      ST_MARK: begin
        wr_en  = 1'b1;
        wr_bit = 1'b1;
        idx_d  = idx_q + BlkCw'(1);
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          free_d  = free_q - FreeW'(bytes_q);
          state_d = ST_DONE;
        end
      end
      ST_FREE: begin
        if (cnt_q == '0 || idx_q == BlkEnd) begin
          free_d  = (credit_sum > (FreeW+1)'(StoreBytes)) ? StoreBytes
                                                          : FreeW'(credit_sum);
          state_d = ST_DONE;
        end else begin
          wr_en = 1'b1;
          idx_d = idx_q + BlkCw'(1);
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = OutDataW'({free_q, pos_q, stat_q});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      cnt_q     <= '0;
      run_q     <= '0;
      free_q    <= StoreBytes;
      rdv_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      free_q    <= free_d;
      rdv_q     <= rd_en;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    bytes_q  <= bytes_d;
    stat_q   <= stat_d;
    pos_q    <= pos_d;
    m_data_q <= m_data_d;
    eval_q   <= idx_q[BlkAw-1:0];
  end

  // block-use bitmap: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q[BlkAw-1:0]] <= wr_bit;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[BlkAw-1:0]];
    end
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= StoreBytes)
    else $error("free byte count above store size");

  a_fail_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && stat_q != STAT_OK) |-> pos_q == '0)
    else $error("failed request carries a position");

  a_mark_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MARK |-> (cnt_q != '0 && idx_q != BlkEnd))
    else $error("mark step past run or store end");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> state_q != ST_IDLE)
    else $error("request accepted without leaving idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> m_valid_q && $stable(m_data_q))
    else $error("pending result lost or changed");

endmodule

// ===== sim/bitmap_first_fit_allocator_core_tb.sv =====
// Self-checking bench for the first-fit bitmap block allocator core.
// Drives allocate and free requests, predicts every reply from a bitmap shadow,
// and compares field by field. Depends on bffa_pkg and the core RTL.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_core_tb;
  import bffa_pkg::*;

  localparam int unsigned WordsPerBlock = BlockBytes / 4;
  localparam int unsigned MaxWords      = NumBlocks * WordsPerBlock;
  localparam int unsigned PosMax        = (1 << PosW) - 1;
  localparam int unsigned NumRandom     = 580;

  typedef struct {
    cmd_e            cmd;
    logic [LenW-1:0] len_words;
    logic [PosW-1:0] free_pos;
  } alloc_req_t;

  typedef struct {
    status_e          status;
    logic [PosW-1:0]  pos;
    logic [FreeW-1:0] free_left;
  } alloc_reply_t;

  typedef struct {
    logic [PosW-1:0] pos;
    logic [LenW-1:0] len_words;
  } alloc_run_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_user = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  // shadow of the block-use bitmap and the free-byte counter
  bit                block_used [NumBlocks];
  longint unsigned   free_bytes = longint'(NumBlocks) * BlockBytes;

  alloc_req_t   pending_reqs[$];
  alloc_reply_t expected_replies[$];
  alloc_run_t   live_runs[$];
  alloc_req_t   cur_req;
  alloc_reply_t drv_reply;
  alloc_reply_t exp_reply;
  int           accepted_cnt = 0;
  int           mismatches = 0;
  int           phase;
  int           send_idle_pct;
  int           recv_stall_pct;

  bitmap_first_fit_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #4 clk_i = ~clk_i;

  // rotate idling phases: none, sender idle, receiver stall, both
  assign phase = (accepted_cnt / 45) % 4;
  always_comb begin
    case (phase)
      1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
      3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  end

  function automatic alloc_reply_t apply_request(input alloc_req_t req);
    alloc_reply_t    r;
    longint unsigned nbytes;
    longint unsigned need;
    longint unsigned run_len;
    longint unsigned start;
    longint unsigned first;
    bit              found;
    alloc_run_t      taken;
    nbytes   = longint'(req.len_words) * 4;
    need     = (nbytes + BlockBytes - 1) / BlockBytes;
    r.status = STAT_OK;
    r.pos    = '0;
    if (req.cmd == CMD_ALLOC) begin
      if (nbytes > free_bytes) begin
        r.status = STAT_NOMEM;
      end else begin
        run_len = 0;
        start   = 0;
        found   = 1'b0;
        if (need != 0) begin
          for (int i = 0; i < NumBlocks; i++) begin
            if (!block_used[i]) begin
              if (run_len == 0) start = i;
              run_len++;
              if (run_len == need) begin
                found = 1'b1;
                break;
              end
            end else begin
              run_len = 0;
            end
          end
        end
        if (found) begin
          for (longint unsigned b = start; b < start + need; b++) block_used[b] = 1'b1;
          r.pos      = PosW'(start * BlockBytes);
          free_bytes = free_bytes - nbytes;
          taken.pos       = r.pos;
          taken.len_words = req.len_words;
          live_runs.push_back(taken);
        end else begin
          r.status = STAT_NORUN;
        end
      end
    end else begin
      first = req.free_pos / BlockBytes;
      // drop blocks that lie past the end of the store
      for (longint unsigned b = first; b < first + need && b < NumBlocks; b++)
        block_used[b] = 1'b0;
      free_bytes = free_bytes + nbytes;
      if (free_bytes > longint'(NumBlocks) * BlockBytes)
        free_bytes = longint'(NumBlocks) * BlockBytes;
    end
    r.free_left = FreeW'(free_bytes);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  task automatic push_req(input cmd_e cmd, input int unsigned len, input int unsigned pos);
    alloc_req_t req;
    req.cmd       = cmd;
    req.len_words = LenW'(len);
    req.free_pos  = PosW'(pos);
    pending_reqs.push_back(req);
  endtask

  task automatic make_random_request(output alloc_req_t req);
    int         r;
    int         k;
    int         idx;
    alloc_run_t run;
    r = $urandom_range(99);
    k = $urandom_range(99);
    req.free_pos = PosW'($urandom_range(0, PosMax));
    if (r < 45) begin
      req.cmd = CMD_ALLOC;
      if (k < 4)       req.len_words = '0;
      else if (k < 10) req.len_words = $urandom_range(1) ? LenW'(MaxWords)
                                                         : LenW'($urandom_range(0, MaxWords));
      else if (k < 55) req.len_words = LenW'($urandom_range(1, 8 * WordsPerBlock));
      else if (k < 80) req.len_words = LenW'(WordsPerBlock * $urandom_range(1, 16));
      else             req.len_words = LenW'($urandom_range(1, 256 * WordsPerBlock));
    end else if (r < 85 && live_runs.size() != 0) begin
      // release a run that an accepted allocate still holds
      idx = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[idx];
      live_runs.delete(idx);
      req.cmd       = CMD_FREE;
      req.len_words = run.len_words;
      req.free_pos  = run.pos;
      if ($urandom_range(3) == 0) req.free_pos = run.pos + PosW'($urandom_range(0, BlockBytes - 1));
    end else begin
      req.cmd = CMD_FREE;
      if (k < 60)      req.len_words = LenW'($urandom_range(0, 4 * WordsPerBlock));
      else if (k < 90) req.len_words = LenW'($urandom_range(0, MaxWords));
      else             req.len_words = LenW'(MaxWords);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        drv_reply = apply_request(cur_req);
        expected_replies.push_back(drv_reply);
        accepted_cnt++;
      end
      if (!s_valid || s_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          s_valid <= 1'b1;
          s_data  <= InDataW'({cur_req.free_pos, cur_req.len_words});
          s_user  <= cur_req.cmd;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", longint'(m_data), 0);
        end else begin
          exp_reply = expected_replies.pop_front();
          if (m_data[1:0] !== exp_reply.status)
            report_mismatch("status", longint'(m_data[1:0]), longint'(exp_reply.status));
          if (m_data[23:2] !== exp_reply.pos)
            report_mismatch("position_bytes", longint'(m_data[23:2]), longint'(exp_reply.pos));
          if (m_data[46:24] !== exp_reply.free_left)
            report_mismatch("free_bytes_left", longint'(m_data[46:24]),
                            longint'(exp_reply.free_left));
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    alloc_req_t req;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(CMD_ALLOC, 0, 0);
    push_req(CMD_ALLOC, MaxWords, 0);                        // whole store
    push_req(CMD_ALLOC, 1, PosMax);                          // no bytes left
    push_req(CMD_ALLOC, 0, 0);                               // zero length on empty count
    push_req(CMD_FREE, 1, 5 * BlockBytes + 123);             // misaligned position
    push_req(CMD_ALLOC, 1, 0);
    push_req(CMD_FREE, MaxWords, 0);
    push_req(CMD_FREE, WordsPerBlock, 0);                    // already free, saturate
    push_req(CMD_ALLOC, 1, 0);
    push_req(CMD_ALLOC, 1, 0);
    push_req(CMD_ALLOC, 1, 0);
    push_req(CMD_ALLOC, MaxWords - 3, 0);                    // bytes fit, blocks do not
    push_req(CMD_FREE, 4 * WordsPerBlock, (NumBlocks - 1) * BlockBytes);  // runs off the end
    push_req(CMD_FREE, MaxWords, PosMax);
    push_req(CMD_FREE, 0, 2 * BlockBytes);
    push_req(CMD_ALLOC, WordsPerBlock, 0);
    push_req(CMD_FREE, 1, BlockBytes);                       // open a one-block hole
    push_req(CMD_ALLOC, 2 * WordsPerBlock, PosMax);          // too big for the hole
    push_req(CMD_ALLOC, WordsPerBlock, 0);                   // fills the hole
    push_req(CMD_ALLOC, MaxWords, 0);
    push_req(CMD_FREE, MaxWords, 0);

    // the last directed request empties the store, so forget its runs
    while (pending_reqs.size() != 0 || s_valid) @(negedge clk_i);
    live_runs.delete();

    for (int n = 0; n < NumRandom; n++) begin
      while (pending_reqs.size() >= 2) @(negedge clk_i);
      make_random_request(req);
      pending_reqs.push_back(req);
    end

    while (pending_reqs.size() != 0 || s_valid) @(negedge clk_i);
    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bffa_pkg.sv
rtl/bitmap_first_fit_allocator_core.sv
sim/bitmap_first_fit_allocator_core_tb.sv
